@@ hdl/mapf_pkg.sv @@
// Shared types, constants and the saturation helper function of the modulated allpass filter.
package mapf_pkg;

  // Default length of the circular delay line in samples.
  localparam int unsigned DELAY_DEPTH_DEF = 4096;

  // Widths fixed by the sample and coefficient formats.
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Saturation bounds of a Q4.20 sample and the coefficient limit of 0.99.
  localparam logic signed [27:0] S24_MAX = 28'sd8388607;
  localparam logic signed [27:0] S24_MIN = -28'sd8388608;
  localparam logic signed [16:0] G_LIMIT = 17'sd32440;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]         BASE_DELAY_RST = 16'd7680;
  localparam logic [CFG_W-1:0]         MIN_DELAY_RST  = 16'd77;
  localparam logic [CFG_W-1:0]         MAX_DELAY_RST  = 16'd30720;
  localparam logic signed [COEF_W-1:0] FEEDBACK_RST   = 16'sd0;

  // Sequencer states for one sample.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_ADDR,
    ST_MUL1,
    ST_SUM1,
    ST_MUL2,
    ST_SUM2
  } state_t;

  // Control strobes from the sequencer to the delay line.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } line_ctrl_t;

  // Clamp a wide signed value to the Q4.20 sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [27:0] v);
    logic signed [27:0] c;
    begin
      if (v > S24_MAX) begin
        c = S24_MAX;
      end else if (v < S24_MIN) begin
        c = S24_MIN;
      end else begin
        c = v;
      end
      return c[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ hdl/mapf_coef.sv @@
// Configuration registers, modulated tap length and modulated allpass coefficient.
module mapf_coef #(
  parameter int unsigned DELAY_DEPTH = mapf_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned AW = $clog2(DELAY_DEPTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [mapf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mapf_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   calc_en,
  input  logic signed [mapf_pkg::COEF_W-1:0]     mod,
  output logic [AW-1:0]                          tap,
  output logic signed [mapf_pkg::COEF_W-1:0]     coef
);

  localparam logic [16:0] TAP_MAX = 17'(DELAY_DEPTH - 1);

  logic [mapf_pkg::CFG_W-1:0]         base_delay;
  logic [mapf_pkg::CFG_W-1:0]         min_delay;
  logic [mapf_pkg::CFG_W-1:0]         max_delay;
  logic signed [mapf_pkg::COEF_W-1:0] feedback;

  logic [16:0]        dq;
  logic signed [17:0] mod_shift;
  logic [32:0]        dq_prod;
  logic signed [31:0] mod_frac;
  logic signed [15:0] coef_add;
  logic signed [16:0] coef_sum;
  logic signed [16:0] coef_clamp;
  logic [16:0]        dq_lo;
  logic [15:0]        dq_hi;
  logic [11:0]        tap_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay <= mapf_pkg::BASE_DELAY_RST;
      min_delay  <= mapf_pkg::MIN_DELAY_RST;
      max_delay  <= mapf_pkg::MAX_DELAY_RST;
      feedback   <= mapf_pkg::FEEDBACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mapf_pkg::CFG_BASE_DELAY: base_delay <= cfg_data;
        mapf_pkg::CFG_MIN_DELAY:  min_delay  <= cfg_data;
        mapf_pkg::CFG_MAX_DELAY:  max_delay  <= cfg_data;
        mapf_pkg::CFG_FEEDBACK:   feedback   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Delay scale is 1 + m/2, held as 65536 + m over a 2^16 scale.
  always_comb begin
    mod_shift = 18'sd65536 + 18'(mod);
    dq_prod   = 33'(base_delay) * 33'(mod_shift[16:0]);
    mod_frac  = 32'(mod) * 32'sd13107 + 32'sd32768;
    coef_add  = mod_frac[31:16];
    coef_sum  = 17'(feedback) + 17'(coef_add);
    if (coef_sum > mapf_pkg::G_LIMIT) begin
      coef_clamp = mapf_pkg::G_LIMIT;
    end else if (coef_sum < -mapf_pkg::G_LIMIT) begin
      coef_clamp = -mapf_pkg::G_LIMIT;
    end else begin
      coef_clamp = coef_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_en) begin
      dq   <= dq_prod[32:16];
      coef <= coef_clamp[15:0];
    end
  end

  // The maximum clamp is applied last, so it wins over the minimum.
  always_comb begin
    dq_lo   = (dq < 17'(min_delay)) ? 17'(min_delay) : dq;
    dq_hi   = (dq_lo > 17'(max_delay)) ? max_delay : dq_lo[15:0];
    tap_raw = dq_hi[15:4];
    if (tap_raw == 12'd0) begin
      tap = AW'(1);
    end else if (17'(tap_raw) > TAP_MAX) begin
      tap = AW'(TAP_MAX);
    end else begin
      tap = AW'(tap_raw);
    end
  end

endmodule

@@ hdl/mapf_delay_line.sv @@
// Circular delay line memory with write pointer and written-entry tracking.
module mapf_delay_line #(
  parameter int unsigned DELAY_DEPTH = mapf_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned AW = $clog2(DELAY_DEPTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mapf_pkg::line_ctrl_t                   ctrl,
  input  logic [AW-1:0]                          tap,
  input  logic signed [mapf_pkg::SAMPLE_W-1:0]   wdata,
  output logic signed [mapf_pkg::SAMPLE_W-1:0]   rdata
);

  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);

  logic signed [mapf_pkg::SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic signed [mapf_pkg::SAMPLE_W-1:0] mem_q;
  logic [AW-1:0] wr_ptr;
  logic          wrapped;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   rd_wrap;

  // Entries are written in order from zero, so an entry holds data once the
  // pointer has passed it or has wrapped at least once. Others read as zero.
  always_comb begin
    rd_wrap = {1'b0, wr_ptr} + DEPTH_X - {1'b0, tap};
    if (wr_ptr >= tap) begin
      rd_addr = wr_ptr - tap;
    end else begin
      rd_addr = rd_wrap[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      mem_q <= mem[rd_addr];
    end
    if (ctrl.wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      wrapped <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      if (ctrl.rd_en) begin
        rd_ok <= wrapped || (rd_addr < wr_ptr);
      end
      if (ctrl.wr_en) begin
        if (wr_ptr == LAST) begin
          wr_ptr  <= '0;
          wrapped <= 1'b1;
        end else begin
          wr_ptr <= wr_ptr + AW'(1);
        end
      end
    end
  end

  assign rdata = rd_ok ? mem_q : '0;

endmodule

@@ hdl/modulated_allpass_filter.sv @@
// Top level of the modulated Schroeder allpass filter.
// The sequencer walks a single sample through coefficient, memory read and two
// multiply-accumulate steps in turn and takes no new word until the last step
// has loaded the output register; a held output word stalls that last step.
// Reset: synchronous, active high; the delay line reads as silence until each
// entry is first written, so no clearing pass is needed and no cycles are lost.
module modulated_allpass_filter #(
  parameter int unsigned DELAY_DEPTH = mapf_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mapf_pkg::SAMPLE_W-1:0]   audio_in,
  input  logic signed [mapf_pkg::COEF_W-1:0]     mod_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mapf_pkg::SAMPLE_W-1:0]   audio_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mapf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mapf_pkg::CFG_W-1:0]             cfg_data
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);

  mapf_pkg::state_t     state;
  mapf_pkg::state_t     state_next;
  mapf_pkg::line_ctrl_t line_ctrl;

  logic in_take;
  logic coef_en;
  logic out_free;
  logic out_load;

  logic signed [mapf_pkg::SAMPLE_W-1:0] x;
  logic signed [mapf_pkg::COEF_W-1:0]   m;
  logic signed [mapf_pkg::COEF_W-1:0]   coef;
  logic [AW-1:0]                        tap;
  logic signed [mapf_pkg::SAMPLE_W-1:0] tap_data;
  logic signed [mapf_pkg::SAMPLE_W-1:0] y;
  logic signed [mapf_pkg::SAMPLE_W-1:0] store_val;

  logic signed [40:0] prod;
  logic signed [16:0] coef_neg;
  logic signed [40:0] rnd1;
  logic signed [40:0] rnd2;
  logic signed [27:0] sum1;
  logic signed [27:0] sum2;

  // Configuration is always writable outside reset; the host is to write only
  // while no sample is in flight, which the block itself does not enforce.
  assign cfg_ready = !rst;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mapf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mapf_pkg::ST_IDLE: if (in_take) state_next = mapf_pkg::ST_COEF;
      mapf_pkg::ST_COEF: state_next = mapf_pkg::ST_ADDR;
      mapf_pkg::ST_ADDR: state_next = mapf_pkg::ST_MUL1;
      mapf_pkg::ST_MUL1: state_next = mapf_pkg::ST_SUM1;
      mapf_pkg::ST_SUM1: state_next = mapf_pkg::ST_MUL2;
      mapf_pkg::ST_MUL2: state_next = mapf_pkg::ST_SUM2;
      mapf_pkg::ST_SUM2: if (out_free) state_next = mapf_pkg::ST_IDLE;
      default: state_next = mapf_pkg::ST_IDLE;
    endcase
  end

  // The last step writes the delay line and loads the output register together,
  // and waits there while a previous output word is still held.
  always_comb begin
    in_stall        = 1'b1;
    coef_en         = 1'b0;
    line_ctrl.rd_en = 1'b0;
    line_ctrl.wr_en = 1'b0;
    out_load        = 1'b0;
    case (state)
      mapf_pkg::ST_IDLE: in_stall = rst;
      mapf_pkg::ST_COEF: coef_en = 1'b1;
      mapf_pkg::ST_ADDR: line_ctrl.rd_en = 1'b1;
      mapf_pkg::ST_SUM2: begin
        line_ctrl.wr_en = out_free;
        out_load        = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x <= audio_in;
      m <= mod_in;
    end
  end

  mapf_coef #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .AW(AW)
  ) u_coef (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .calc_en(coef_en),
    .mod(m),
    .tap(tap),
    .coef(coef)
  );

  mapf_delay_line #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .AW(AW)
  ) u_line (
    .clk(clk),
    .rst(rst),
    .ctrl(line_ctrl),
    .tap(tap),
    .wdata(store_val),
    .rdata(tap_data)
  );

  // One product register is shared by both multiplies. Each product is
  // rounded to Q4.20 by adding half an LSB and taking the floor. A rounded
  // product stays within 25 signed bits, so its low 28 bits keep the sign.
  always_comb begin
    coef_neg  = -17'(coef);
    rnd1      = (prod + 41'sd16384) >>> 15;
    rnd2      = (prod + 41'sd16384) >>> 15;
    sum1      = signed'(rnd1[27:0]) + 28'(tap_data);
    sum2      = signed'(rnd2[27:0]) + 28'(x);
    store_val = mapf_pkg::sat24(sum2);
  end

  always_ff @(posedge clk) begin
    case (state)
      mapf_pkg::ST_MUL1: prod <= 41'(coef_neg) * 41'(x);
      mapf_pkg::ST_SUM1: y <= mapf_pkg::sat24(sum1);
      mapf_pkg::ST_MUL2: prod <= 41'(coef) * 41'(y);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      audio_out <= y;
    end
  end

endmodule

@@ hdl/mapf_checker.sv @@
// Port-level assertions for the modulated allpass filter and their bind.
module mapf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [mapf_pkg::SAMPLE_W-1:0]   audio_out
);

  // A held output word keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(audio_out))
    else $error("output word changed while stalled");

  // No output word is left over from before reset.
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // Only one sample is processed at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // A new output word only appears at the end of a sample's processing.
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word appeared while idle");

endmodule

bind modulated_allpass_filter mapf_checker u_mapf_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .audio_out(audio_out)
);

@@ tb/sv/allpass_response_check.sv @@
`timescale 1ns / 100ps
// Port monitor that predicts every filtered sample and compares it with the block's output.
module allpass_response_check
  import mapf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] audio_in,
  input  logic signed [COEF_W-1:0]   mod_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] audio_out,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         mismatch_count,
  output int                         words_in_flight
);

  localparam int DEPTH = DELAY_DEPTH_DEF;
  localparam longint signed Q420_HI = 8388607;
  localparam longint signed Q420_LO = -8388608;
  localparam longint signed COEF_LIM = 32440;
  localparam int PRINT_CAP = 50;

  // Own copy of the delay line, write pointer and register file.
  logic signed [SAMPLE_W-1:0] line_mem [DEPTH];
  int                         wr_ptr;
  logic [CFG_W-1:0]           base_q4;
  logic [CFG_W-1:0]           min_q4;
  logic [CFG_W-1:0]           max_q4;
  logic signed [COEF_W-1:0]   fb_q15;

  // Output samples still owed by the block, oldest first.
  logic signed [SAMPLE_W-1:0] expected_out [$];

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip_q420(input longint signed v);
    longint signed c;
    c = v;
    if (c > Q420_HI) begin
      c = Q420_HI;
    end else if (c < Q420_LO) begin
      c = Q420_LO;
    end
    return c[SAMPLE_W-1:0];
  endfunction

  // Q1.15 times Q4.20, rounded back to Q4.20 (arithmetic shift floors).
  function automatic longint signed scale_round(input longint signed a, input longint signed b);
    return (a * b + 16384) >>> 15;
  endfunction

  // Advances the filter by one sample and returns the sample it puts out.
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] x, input logic signed [COEF_W-1:0] m);
    longint signed xs, ms, dq, tap, g, d, y;
    int rd;
    xs = x;
    ms = m;
    // The delay swings by half the modulation; the max clamp comes last.
    dq = (longint'(base_q4) * (65536 + ms)) >>> 16;
    if (dq < longint'(min_q4)) dq = longint'(min_q4);
    if (dq > longint'(max_q4)) dq = longint'(max_q4);
    tap = dq >>> 4;
    if (tap < 1) tap = 1;
    if (tap > DEPTH - 1) tap = DEPTH - 1;
    // The coefficient moves by a fifth of the modulation, rounded.
    g = longint'(fb_q15) + ((ms * 13107 + 32768) >>> 16);
    if (g > COEF_LIM) g = COEF_LIM;
    if (g < -COEF_LIM) g = -COEF_LIM;
    rd = (wr_ptr + DEPTH - int'(tap)) % DEPTH;
    d = line_mem[rd];
    y = clip_q420(d + scale_round(-g, xs));
    line_mem[wr_ptr] = clip_q420(xs + scale_round(g, y));
    wr_ptr = (wr_ptr + 1) % DEPTH;
    return y[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch_ports
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_ptr = 0;
      base_q4 = BASE_DELAY_RST;
      min_q4 = MIN_DELAY_RST;
      max_q4 = MAX_DELAY_RST;
      fb_q15 = FEEDBACK_RST;
      expected_out.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_DELAY: base_q4 = cfg_data;
          CFG_MIN_DELAY:  min_q4 = cfg_data;
          CFG_MAX_DELAY:  max_q4 = cfg_data;
          CFG_FEEDBACK:   fb_q15 = cfg_data;
          default: ;
        endcase
      end
      // Retire the oldest expectation before adding this edge's new one.
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("output word %0d with no input word waiting", audio_out));
        end else begin
          want = expected_out.pop_front();
          if (audio_out !== want) begin
            report_mismatch($sformatf("audio_out %0d, expected %0d", audio_out, want));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_out.push_back(filter_sample(audio_in, mod_in));
      end
    end
    words_in_flight <= expected_out.size();
  end

endmodule

@@ tb/sv/modulated_allpass_filter_test.sv @@
`timescale 1ns / 100ps
// Top of the allpass filter testbench: clock, reset, stimulus, output pacing and verdict.
module modulated_allpass_filter_test;
  import mapf_pkg::*;

  // The cycle limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1700;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;

  localparam logic signed [SAMPLE_W-1:0] X_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] X_MIN = 24'sh800000;
  localparam logic signed [COEF_W-1:0]   M_MAX = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0]   M_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   G_HI  = 16'sd32440;
  localparam logic signed [COEF_W-1:0]   G_LO  = -16'sd32440;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] audio_in = '0;
  logic signed [COEF_W-1:0]   mod_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] audio_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  int mismatch_count;
  int words_in_flight;

  // Sender pacing: words go out in bursts separated by idle gaps. In a steady
  // phase the gaps are zero, so the input is offered back to back.
  int burst_left = 0;
  int gap_left = 0;
  bit steady_sender = 1'b0;
  int sent_words = 0;

  modulated_allpass_filter u_dut (.*);

  allpass_response_check u_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one word and returns at the edge where the block takes it. The
  // payload is only changed after acceptance, so a stalled word stays put.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] x,
                           input logic signed [COEF_W-1:0] m);
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    audio_in <= x;
    mod_in <= m;
    do @(posedge clk); while (in_stall);
    sent_words++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left = steady_sender ? 0 : $urandom_range(0, 14);
    end
  endtask

  // Stops offering and waits until the monitor has seen every owed output.
  // Every word yields exactly one output, so an empty list means the block
  // is idle and registers may be rewritten.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
  endtask

  // Writes one register. The valid line is left high so that back-to-back
  // writes never lower and raise it in the same step.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] hi, input logic signed [COEF_W-1:0] fb);
    put_reg(CFG_BASE_DELAY, base);
    put_reg(CFG_MIN_DELAY, lo);
    put_reg(CFG_MAX_DELAY, hi);
    put_reg(CFG_FEEDBACK, fb);
    cfg_valid <= 1'b0;
  endtask

  // Output pacing. Each run of cycles picks one pattern: no stall at all,
  // light random stall, heavy random stall, or a fixed on/off rhythm. Twice
  // in the run, while the sender is offering, the output is held off for a
  // long stretch so that the block backs up and stalls its input.
  initial begin : out_pacing
    int pattern;
    int run;
    int period;
    int held;
    held = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      pattern = $urandom_range(3);
      run = $urandom_range(20, 150);
      period = $urandom_range(2, 9);
      for (int c = 0; c < run; c++) begin
        if (held < 2 && in_valid && sent_words >= 250 + 750 * held) begin
          held++;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (pattern)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(3) != 0);
          default: out_stall <= ((c % period) < (period / 2));
        endcase
        @(posedge clk);
      end
    end
  end

  // Hard stop in case the block hangs or withholds outputs.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int phase_words;
    int random_sent;
    int fb_pick;
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic signed [COEF_W-1:0] fb;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [COEF_W-1:0] m;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: sample and modulation extremes with a silent line.
    send_word(X_MAX, '0);
    send_word(X_MIN, '0);
    send_word('0, M_MIN);
    send_word(X_MAX, M_MAX);
    send_word(X_MIN, M_MIN);
    send_word(-24'sd1, 16'sd1);

    // Shortest tap with a feedback register beyond 0.99. The full negative
    // swing pulls the tap below one, where it is held at one.
    wait_drained();
    load_settings(16'd16, 16'd0, 16'hFFFF, M_MAX);
    send_word(X_MAX, '0);
    send_word(X_MAX, M_MAX);
    send_word(X_MIN, M_MIN);
    send_word(X_MIN, '0);
    send_word('0, '0);

    // Longest base delay: the tap runs into its upper bound. The feedback
    // register sits at its most negative code.
    wait_drained();
    load_settings(16'hFFFF, 16'd0, 16'hFFFF, M_MIN);
    send_word(X_MAX, M_MAX);
    send_word(X_MIN, '0);
    send_word(X_MAX, M_MIN);
    send_word('0, M_MAX);

    // Minimum clamp above the maximum clamp: the maximum decides the tap.
    wait_drained();
    load_settings(16'd7680, 16'd60000, 16'd100, G_HI);
    send_word(X_MAX, '0);
    send_word(X_MIN, M_MAX);
    send_word(24'sd1048576, M_MIN);
    send_word(-24'sd1048576, 16'sd16384);
    send_word(X_MAX, -16'sd16384);

    // All delay registers at zero and the feedback register at the coefficient's negative limit.
    wait_drained();
    load_settings(16'd0, 16'd0, 16'd0, G_LO);
    send_word(X_MAX, M_MIN);
    send_word(X_MIN, M_MAX);
    send_word(24'sd12345, '0);

    // Random phases. Each one drains the block, loads fresh settings and
    // sends a batch of words. Short base delays dominate so that the tap
    // reaches samples written within this run and the recursion shows.
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      wait_drained();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: base = 16'($urandom_range(0, 1200));
        5, 6, 7:       base = 16'($urandom_range(0, 20000));
        8:             base = 16'hFFFF;
        default:       base = 16'($urandom());
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: lo = 16'($urandom_range(0, 400));
        7, 8:                lo = 16'($urandom());
        default:             lo = '0;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: hi = 16'($urandom_range(30000, 65535));
        7:                   hi = '0;
        8:                   hi = 16'hFFFF;
        default:             hi = 16'($urandom());
      endcase
      case ($urandom_range(9))
        6:       fb = G_HI;
        7:       fb = G_LO;
        8:       fb = M_MAX;
        9:       fb = M_MIN;
        default: begin
          fb_pick = $urandom_range(0, 64880);
          fb = 16'(fb_pick - 32440);
        end
      endcase
      load_settings(base, lo, hi, fb);
      steady_sender = ($urandom_range(3) == 0);
      phase_words = $urandom_range(80, 200);
      repeat (phase_words) begin
        // Mix full-scale noise with quieter signals so that not every
        // output lands on a saturation rail.
        x = 24'($urandom());
        case ($urandom_range(11))
          0:          x = X_MAX;
          1:          x = X_MIN;
          2:          x = {{16{x[7]}}, x[7:0]};
          3, 4, 5:    x = {{4{x[19]}}, x[19:0]};
          default:    ;
        endcase
        m = 16'($urandom());
        case ($urandom_range(9))
          0:       m = M_MAX;
          1:       m = M_MIN;
          2:       m = '0;
          default: ;
        endcase
        send_word(x, m);
      end
      random_sent += phase_words;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ modulated_allpass_filter.f @@
hdl/mapf_pkg.sv
hdl/mapf_coef.sv
hdl/mapf_delay_line.sv
hdl/modulated_allpass_filter.sv
hdl/mapf_checker.sv
tb/sv/allpass_response_check.sv
tb/sv/modulated_allpass_filter_test.sv
